// File: src/ssdbm_pkg.sv
`default_nettype none

package ssdbm_pkg;

   // Default sizes for the top-level parameters
   localparam int WINDOW_DEFAULT     = 3;
   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 1024;

   // Fixed field widths
   localparam int CFG_W     = 11;
   localparam int PIX_W     = 8;
   localparam int SCALE_W   = 8;
   localparam int COORD_W   = 10;
   localparam int CSR_IDX_W = 2;
   localparam int SQ_W      = 2 * PIX_W;
   localparam int SQ_MAX    = 65025;
   localparam int RESULT_W  = 2 * COORD_W + SCALE_W + 1;

   // Register reset values
   localparam logic [CFG_W-1:0]   WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_W-1:0]   HEIGHT_RESET = 11'd1024;
   localparam logic [SCALE_W-1:0] SCALE_RESET  = 8'd3;

   // Saturation limit of the disparity output
   localparam logic [SCALE_W-1:0] VALUE_MAX = 8'd255;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH     = 2'd0,
      CSR_IMAGE_HEIGHT    = 2'd1,
      CSR_DISPARITY_SCALE = 2'd2
   } csr_index_type;

   // Input item kinds
   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

endpackage

`default_nettype wire

// File: src/ssd_block_match_disparity.sv
// SSD block-matching stereo disparity.
// Input queue: req_op/req_left_pixel/req_right_pixel, taken when req_push is
// high and req_full is low. Pixel pairs come in raster order; a flush
// transaction stores nothing and only lets pending results out.
// Result queue: rsp_* hold the oldest result while rsp_empty is low; it is
// taken when rsp_pop is high. A two-entry result queue lets the receiver
// stall without blocking transactions that give no result.
// Registers (csr_we, csr_index, csr_wdata): 0 image width, 1 image height,
// 2 disparity scale. Write them only while the block is idle.
// Timing: a transaction that gives no result does not raise req_full. One
// that gives a result holds req_full high while the search runs: one
// line-store read per patch term for each of the width - 2*HALF candidate
// columns (1022 for the default 3x3 window on a 1024 wide image), followed
// by job handoff, pipeline drain and scaling. The result reaches the rsp_
// ports in the cycle req_full falls. When the result queue is full, the
// search holds its result and req_full stays high until the receiver pops.
// Reset restores the registers, the raster position and empties both
// queues; the line stores are not cleared and need no clearing pass.
`default_nettype none

module ssd_block_match_disparity #(
   parameter int WINDOW     = ssdbm_pkg::WINDOW_DEFAULT,
   parameter int MAX_WIDTH  = ssdbm_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = ssdbm_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [ssdbm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ssdbm_pkg::CFG_W-1:0]       csr_wdata,
   input  wire logic                              req_push,
   input  wire logic                              req_op,
   input  wire logic [ssdbm_pkg::PIX_W-1:0]       req_left_pixel,
   input  wire logic [ssdbm_pkg::PIX_W-1:0]       req_right_pixel,
   output logic                                   req_full,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic      [ssdbm_pkg::COORD_W-1:0]     rsp_out_row,
   output logic      [ssdbm_pkg::COORD_W-1:0]     rsp_out_col,
   output logic      [ssdbm_pkg::SCALE_W-1:0]     rsp_disparity_value,
   output logic                                   rsp_last_of_image
);

   localparam int HALF  = WINDOW / 2;
   localparam int SLOTS = 2 * HALF + 2;
   localparam int SW    = $clog2(SLOTS);
   localparam int XW    = $clog2(MAX_WIDTH + 1);
   localparam int AW    = $clog2(SLOTS * MAX_WIDTH);
   localparam int JOBW  = SW + XW + ssdbm_pkg::COORD_W + 1;

   logic                          accept;
   logic                          st_we;
   logic [AW-1:0]                 st_addr;
   logic [ssdbm_pkg::PIX_W-1:0]   st_left, st_right;
   logic                          job_push, job_pop, job_full, job_empty;
   logic [JOBW-1:0]               job_data, job_head;
   logic [XW-1:0]                 eff_w;
   logic [ssdbm_pkg::SCALE_W-1:0] scale;
   logic [AW-1:0]                 rd_left_addr, rd_right_addr;
   logic [ssdbm_pkg::PIX_W-1:0]   rd_left, rd_right;
   logic                          res_push, res_full;
   logic [ssdbm_pkg::RESULT_W-1:0] res_data, res_head;
   logic                          back_busy;

   // Hold input while a search is queued or running
   assign req_full = !job_empty || back_busy;
   assign accept   = req_push && !req_full;

   ssdbm_front #(
      .WINDOW     (WINDOW),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .accept          (accept),
      .req_op          (req_op),
      .req_left_pixel  (req_left_pixel),
      .req_right_pixel (req_right_pixel),
      .st_we           (st_we),
      .st_addr         (st_addr),
      .st_left         (st_left),
      .st_right        (st_right),
      .job_push        (job_push),
      .job_data        (job_data),
      .eff_w           (eff_w),
      .scale           (scale)
   );

   ssdbm_ram #(
      .WIDTH (ssdbm_pkg::PIX_W),
      .DEPTH (SLOTS * MAX_WIDTH)
   ) u_left_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_addr),
      .wr_data (st_left),
      .rd_addr (rd_left_addr),
      .rd_data (rd_left)
   );

   ssdbm_ram #(
      .WIDTH (ssdbm_pkg::PIX_W),
      .DEPTH (SLOTS * MAX_WIDTH)
   ) u_right_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_addr),
      .wr_data (st_right),
      .rd_addr (rd_right_addr),
      .rd_data (rd_right)
   );

   ssdbm_fifo #(
      .WIDTH (JOBW),
      .DEPTH (2)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .pop       (job_pop),
      .head_data (job_head),
      .full      (job_full),
      .empty     (job_empty)
   );

   ssdbm_back #(
      .WINDOW    (WINDOW),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (!job_empty),
      .job_data      (job_head),
      .job_pop       (job_pop),
      .eff_w         (eff_w),
      .scale         (scale),
      .rd_left_addr  (rd_left_addr),
      .rd_right_addr (rd_right_addr),
      .rd_left       (rd_left),
      .rd_right      (rd_right),
      .res_push      (res_push),
      .res_data      (res_data),
      .res_full      (res_full),
      .busy          (back_busy)
   );

   ssdbm_fifo #(
      .WIDTH (ssdbm_pkg::RESULT_W),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .pop       (rsp_pop),
      .head_data (res_head),
      .full      (res_full),
      .empty     (rsp_empty)
   );

   assign {rsp_out_row, rsp_out_col, rsp_disparity_value, rsp_last_of_image} = res_head;

   // Jobs never overflow the job queue
   assert property (@(posedge clock) disable iff (reset) !(job_push && job_full))
      else $error("job queue overflow");

   // Line stores are never written while a search reads them
   assert property (@(posedge clock) disable iff (reset) st_we |-> !back_busy)
      else $error("line store written during search");

   // Results are only handed over when the result queue has room
   assert property (@(posedge clock) disable iff (reset) res_push |-> !res_full)
      else $error("result queue overflow");

   // The result path and the search are empty right after reset
   assert property (@(posedge clock) (!reset && $past(reset)) |-> (rsp_empty && !back_busy))
      else $error("state not cleared by reset");

endmodule

`default_nettype wire

// File: src/ssdbm_ram.sv
`default_nettype none

module ssdbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/ssdbm_fifo.sv
`default_nettype none

module ssdbm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] head_data,
   output logic                  full,
   output logic                  empty
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: src/ssdbm_front.sv
`default_nettype none

module ssdbm_front #(
   parameter int WINDOW     = ssdbm_pkg::WINDOW_DEFAULT,
   parameter int MAX_WIDTH  = ssdbm_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = ssdbm_pkg::MAX_HEIGHT_DEFAULT,
   localparam int HALF  = WINDOW / 2,
   localparam int SLOTS = 2 * HALF + 2,
   localparam int SW    = $clog2(SLOTS),
   localparam int XW    = $clog2(MAX_WIDTH + 1),
   localparam int YW    = $clog2(MAX_HEIGHT + 1),
   localparam int AW    = $clog2(SLOTS * MAX_WIDTH),
   localparam int JOBW  = SW + XW + ssdbm_pkg::COORD_W + 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // register writes
   input  wire logic                              csr_we,
   input  wire logic [ssdbm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ssdbm_pkg::CFG_W-1:0]       csr_wdata,
   // accepted input transaction
   input  wire logic                              accept,
   input  wire logic                              req_op,
   input  wire logic [ssdbm_pkg::PIX_W-1:0]       req_left_pixel,
   input  wire logic [ssdbm_pkg::PIX_W-1:0]       req_right_pixel,
   // line store write
   output logic                                   st_we,
   output logic      [AW-1:0]                     st_addr,
   output logic      [ssdbm_pkg::PIX_W-1:0]       st_left,
   output logic      [ssdbm_pkg::PIX_W-1:0]       st_right,
   // search job
   output logic                                   job_push,
   output logic      [JOBW-1:0]                   job_data,
   // settings used by the search
   output logic      [XW-1:0]                     eff_w,
   output logic      [ssdbm_pkg::SCALE_W-1:0]     scale
);

   logic [ssdbm_pkg::CFG_W-1:0]   width_ff, width_in;
   logic [ssdbm_pkg::CFG_W-1:0]   height_ff, height_in;
   logic [ssdbm_pkg::SCALE_W-1:0] scale_ff, scale_in;
   logic [YW-1:0] in_row_ff, in_row_in;
   logic [XW-1:0] in_col_ff, in_col_in;
   logic [SW-1:0] in_slot_ff, in_slot_in;
   logic [SW-1:0] cur_base_ff, cur_base_in;
   logic [YW-1:0] pend_row_ff, pend_row_in;
   logic [XW-1:0] pend_col_ff, pend_col_in;
   logic [SW-1:0] pend_slot_ff, pend_slot_in;
   logic          lagging_ff, lagging_in;

   logic [YW-1:0] eff_h;
   logic          interior;
   logic [YW-1:0] row_a, prow_a;
   logic [XW-1:0] col_a, pcol_a;
   logic [SW-1:0] slot_a, base_a, pslot_a, back_slot;
   logic          lag_a;
   logic [XW-1:0] col_inc, pcol_inc;
   logic [YW-1:0] row_inc, prow_inc;
   logic          ready;
   logic          job_last;
   logic [ssdbm_pkg::COORD_W-1:0] job_row;

   // Clamp the size registers to the supported range
   always_comb begin
      if (width_ff == '0) begin
         eff_w = XW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = XW'(MAX_WIDTH);
      end else begin
         eff_w = XW'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = YW'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = YW'(MAX_HEIGHT);
      end else begin
         eff_h = YW'(height_ff);
      end
   end

   assign scale    = scale_ff;
   assign interior = (32'(eff_w) > 32'(2 * HALF)) && (32'(eff_h) > 32'(2 * HALF));

   // Store the pixel pair at the raster position
   assign st_we    = accept && (req_op == ssdbm_pkg::OP_PIXEL);
   assign st_addr  = AW'(in_slot_ff) * AW'(MAX_WIDTH) + AW'(in_col_ff);
   assign st_left  = req_left_pixel;
   assign st_right = req_right_pixel;

   assign col_inc   = in_col_ff + 1'b1;
   assign row_inc   = in_row_ff + 1'b1;
   assign back_slot = (in_slot_ff >= SW'(2 * HALF)) ? in_slot_ff - SW'(2 * HALF)
                                                    : in_slot_ff + SW'(SLOTS - 2 * HALF);

   // Advance the raster position, then classify the transaction
   always_comb begin
      row_a    = in_row_ff;
      col_a    = in_col_ff;
      slot_a   = in_slot_ff;
      base_a   = cur_base_ff;
      prow_a   = pend_row_ff;
      pcol_a   = pend_col_ff;
      pslot_a  = pend_slot_ff;
      lag_a    = lagging_ff;
      job_last = 1'b0;
      if (st_we) begin
         if (col_inc >= eff_w) begin
            col_a  = '0;
            row_a  = row_inc;
            slot_a = (in_slot_ff == SW'(SLOTS - 1)) ? '0 : in_slot_ff + 1'b1;
            if (row_inc >= eff_h) begin
               row_a  = '0;
               base_a = slot_a;
               prow_a = YW'(HALF);
               if (lagging_ff) begin
                  // drop the unfinished earlier image
                  pcol_a  = XW'(HALF);
                  lag_a   = 1'b0;
                  pslot_a = slot_a;
               end else if (interior) begin
                  lag_a   = 1'b1;
                  prow_a  = eff_h - YW'(1) - YW'(HALF);
                  pslot_a = back_slot;
               end else begin
                  lag_a   = 1'b0;
                  pcol_a  = XW'(HALF);
                  pslot_a = slot_a;
               end
            end
         end else begin
            col_a = col_inc;
         end
      end

      ready = accept && interior &&
              (lag_a || ({1'b0, row_a} > ({1'b0, prow_a} + (YW + 1)'(HALF))));
      job_push = ready;
      job_row  = ssdbm_pkg::COORD_W'(prow_a - YW'(HALF));

      pend_row_in  = prow_a;
      pend_col_in  = pcol_a;
      pend_slot_in = pslot_a;
      lagging_in   = lag_a;
      pcol_inc     = pcol_a + 1'b1;
      prow_inc     = prow_a + 1'b1;
      if (ready) begin
         if (pcol_inc >= eff_w - XW'(HALF)) begin
            pend_col_in = XW'(HALF);
            if (prow_inc >= eff_h - YW'(HALF)) begin
               pend_row_in  = YW'(HALF);
               pend_slot_in = base_a;
               lagging_in   = 1'b0;
               job_last     = 1'b1;
            end else begin
               pend_row_in  = prow_inc;
               pend_slot_in = (pslot_a == SW'(SLOTS - 1)) ? '0 : pslot_a + 1'b1;
            end
         end else begin
            pend_col_in = pcol_inc;
         end
      end

      in_row_in   = row_a;
      in_col_in   = col_a;
      in_slot_in  = slot_a;
      cur_base_in = base_a;
      width_in    = width_ff;
      height_in   = height_ff;
      scale_in    = scale_ff;

      // Register writes; a size write restarts the frame
      if (csr_we) begin
         case (ssdbm_pkg::csr_index_type'(csr_index))
            ssdbm_pkg::CSR_IMAGE_WIDTH,
            ssdbm_pkg::CSR_IMAGE_HEIGHT: begin
               if (ssdbm_pkg::csr_index_type'(csr_index) == ssdbm_pkg::CSR_IMAGE_WIDTH) begin
                  width_in = csr_wdata;
               end else begin
                  height_in = csr_wdata;
               end
               in_row_in    = '0;
               in_col_in    = '0;
               in_slot_in   = cur_base_ff;
               cur_base_in  = cur_base_ff;
               pend_row_in  = YW'(HALF);
               pend_col_in  = XW'(HALF);
               pend_slot_in = cur_base_ff;
               lagging_in   = 1'b0;
            end
            ssdbm_pkg::CSR_DISPARITY_SCALE: begin
               scale_in = csr_wdata[ssdbm_pkg::SCALE_W-1:0];
            end
            default: begin
               scale_in = scale_ff;
            end
         endcase
      end
   end

   assign job_data = {pslot_a, pcol_a, job_row, job_last};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= ssdbm_pkg::WIDTH_RESET;
         height_ff    <= ssdbm_pkg::HEIGHT_RESET;
         scale_ff     <= ssdbm_pkg::SCALE_RESET;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_slot_ff   <= '0;
         cur_base_ff  <= '0;
         pend_row_ff  <= YW'(HALF);
         pend_col_ff  <= XW'(HALF);
         pend_slot_ff <= '0;
         lagging_ff   <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         scale_ff     <= scale_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         in_slot_ff   <= in_slot_in;
         cur_base_ff  <= cur_base_in;
         pend_row_ff  <= pend_row_in;
         pend_col_ff  <= pend_col_in;
         pend_slot_ff <= pend_slot_in;
         lagging_ff   <= lagging_in;
      end
   end

endmodule

`default_nettype wire

// File: src/ssdbm_back.sv
`default_nettype none

module ssdbm_back #(
   parameter int WINDOW    = ssdbm_pkg::WINDOW_DEFAULT,
   parameter int MAX_WIDTH = ssdbm_pkg::MAX_WIDTH_DEFAULT,
   localparam int HALF  = WINDOW / 2,
   localparam int PATCH = 2 * HALF + 1,
   localparam int SLOTS = 2 * HALF + 2,
   localparam int SW    = $clog2(SLOTS),
   localparam int XW    = $clog2(MAX_WIDTH + 1),
   localparam int AW    = $clog2(SLOTS * MAX_WIDTH),
   localparam int JOBW  = SW + XW + ssdbm_pkg::COORD_W + 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // search job
   input  wire logic                               job_valid,
   input  wire logic [JOBW-1:0]                    job_data,
   output logic                                    job_pop,
   // settings
   input  wire logic [XW-1:0]                      eff_w,
   input  wire logic [ssdbm_pkg::SCALE_W-1:0]      scale,
   // line store reads
   output logic      [AW-1:0]                      rd_left_addr,
   output logic      [AW-1:0]                      rd_right_addr,
   input  wire logic [ssdbm_pkg::PIX_W-1:0]        rd_left,
   input  wire logic [ssdbm_pkg::PIX_W-1:0]        rd_right,
   // results
   output logic                                    res_push,
   output logic      [ssdbm_pkg::RESULT_W-1:0]     res_data,
   input  wire logic                               res_full,
   output logic                                    busy
);

   localparam int UW   = (PATCH > 1) ? $clog2(PATCH) : 1;
   localparam int SUMW = $clog2(PATCH * PATCH * ssdbm_pkg::SQ_MAX + 1);
   localparam int PW   = XW + ssdbm_pkg::SCALE_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT,
      ST_CALC,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic [XW-1:0]                   j_ff, j_in;
   logic [ssdbm_pkg::COORD_W-1:0]   orow_ff, orow_in;
   logic                            last_ff, last_in;
   logic [SW-1:0]                   top_ff, top_in;
   logic [XW-1:0]                   c_ff, c_in;
   logic [UW-1:0]                   u_ff, u_in;
   logic [UW-1:0]                   v_ff, v_in;
   logic [SW-1:0]                   slot_ff, slot_in;
   logic                            p1_valid_ff, p1_valid_in;
   logic                            p1_end_ff, p1_end_in;
   logic                            p1_final_ff, p1_final_in;
   logic [XW-1:0]                   p1_c_ff, p1_c_in;
   logic                            p2_valid_ff, p2_valid_in;
   logic                            p2_end_ff, p2_end_in;
   logic                            p2_final_ff, p2_final_in;
   logic [XW-1:0]                   p2_c_ff, p2_c_in;
   logic [ssdbm_pkg::SQ_W-1:0]      sq_ff, sq_in;
   logic [SUMW-1:0]                 acc_ff, acc_in;
   logic [SUMW-1:0]                 best_ff, best_in;
   logic [XW-1:0]                   best_c_ff, best_c_in;
   logic                            have_ff, have_in;
   logic [ssdbm_pkg::SCALE_W-1:0]   val_ff, val_in;

   logic [XW-1:0]                   c_last;
   logic                            cand_end, final_issue;
   logic [ssdbm_pkg::PIX_W-1:0]     mag;
   logic [SUMW-1:0]                 total;
   logic [XW-1:0]                   disp;
   logic [PW-1:0]                   prod;

   assign c_last      = eff_w - XW'(HALF) - XW'(1);
   assign cand_end    = (u_ff == UW'(PATCH - 1)) && (v_ff == UW'(PATCH - 1));
   assign final_issue = cand_end && (c_ff == c_last);
   assign busy        = (state_ff != ST_IDLE);

   // Patch addresses for the current term
   assign rd_left_addr  = AW'(slot_ff) * AW'(MAX_WIDTH)
                        + AW'(j_ff + XW'(v_ff) - XW'(HALF));
   assign rd_right_addr = AW'(slot_ff) * AW'(MAX_WIDTH)
                        + AW'(c_ff + XW'(v_ff) - XW'(HALF));

   assign mag   = (rd_left >= rd_right) ? rd_left - rd_right : rd_right - rd_left;
   assign total = acc_ff + SUMW'(sq_ff);
   assign disp  = (best_c_ff >= j_ff) ? best_c_ff - j_ff : j_ff - best_c_ff;
   assign prod  = PW'(disp) * PW'(scale);

   assign res_data = {orow_ff, ssdbm_pkg::COORD_W'(j_ff - XW'(HALF)), val_ff, last_ff};

   always_comb begin
      state_in  = state_ff;
      j_in      = j_ff;
      orow_in   = orow_ff;
      last_in   = last_ff;
      top_in    = top_ff;
      c_in      = c_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      slot_in   = slot_ff;
      acc_in    = acc_ff;
      best_in   = best_ff;
      best_c_in = best_c_ff;
      have_in   = have_ff;
      val_in    = val_ff;
      job_pop   = 1'b0;
      res_push  = 1'b0;

      // Issue stage tags travel with the read data
      p1_valid_in = (state_ff == ST_RUN);
      p1_end_in   = cand_end;
      p1_final_in = final_issue;
      p1_c_in     = c_ff;

      // Square stage
      p2_valid_in = p1_valid_ff;
      p2_end_in   = p1_end_ff;
      p2_final_in = p1_final_ff;
      p2_c_in     = p1_c_ff;
      sq_in       = ssdbm_pkg::SQ_W'(mag) * ssdbm_pkg::SQ_W'(mag);

      // Accumulate stage; keep the first smallest sum
      if (p2_valid_ff) begin
         if (p2_end_ff) begin
            acc_in = '0;
            if (!have_ff || (total < best_ff)) begin
               best_in   = total;
               best_c_in = p2_c_ff;
            end
            have_in = 1'b1;
         end else begin
            acc_in = total;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               {top_in, j_in, orow_in, last_in} = job_data;
               slot_in  = job_data[JOBW-1 -: SW];
               c_in     = XW'(HALF);
               u_in     = '0;
               v_in     = '0;
               acc_in   = '0;
               have_in  = 1'b0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // Walk columns of the patch, then rows, then candidates
            if (v_ff == UW'(PATCH - 1)) begin
               v_in = '0;
               if (u_ff == UW'(PATCH - 1)) begin
                  u_in    = '0;
                  slot_in = top_ff;
                  c_in    = c_ff + 1'b1;
                  if (final_issue) begin
                     state_in = ST_WAIT;
                  end
               end else begin
                  u_in    = u_ff + 1'b1;
                  slot_in = (slot_ff == SW'(SLOTS - 1)) ? '0 : slot_ff + 1'b1;
               end
            end else begin
               v_in = v_ff + 1'b1;
            end
         end
         ST_WAIT: begin
            if (p2_valid_ff && p2_final_ff) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            val_in   = (prod > PW'(ssdbm_pkg::VALUE_MAX)) ? ssdbm_pkg::VALUE_MAX
                                                          : prod[ssdbm_pkg::SCALE_W-1:0];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      j_ff      <= j_in;
      orow_ff   <= orow_in;
      last_ff   <= last_in;
      top_ff    <= top_in;
      c_ff      <= c_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      slot_ff   <= slot_in;
      p1_end_ff   <= p1_end_in;
      p1_final_ff <= p1_final_in;
      p1_c_ff     <= p1_c_in;
      p2_end_ff   <= p2_end_in;
      p2_final_ff <= p2_final_in;
      p2_c_ff     <= p2_c_in;
      sq_ff     <= sq_in;
      acc_ff    <= acc_in;
      best_ff   <= best_in;
      best_c_ff <= best_c_in;
      have_ff   <= have_in;
      val_ff    <= val_in;
      if (reset) begin
         state_ff    <= ST_IDLE;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
      end
   end

endmodule

`default_nettype wire
